FILE: hdl/kcs_host_transaction_sequencer_defines.svh
// Assertion macros for the KCS host transaction sequencer.
// Included by the modules that carry assertions; no other dependencies.
`ifndef KCS_HOST_TRANSACTION_SEQUENCER_DEFINES_SVH
`define KCS_HOST_TRANSACTION_SEQUENCER_DEFINES_SVH
`ifndef SYNTH
`define KCS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kcs assertion failed");
`define KCS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kcs assertion failed");
`define KCS_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("kcs assertion failed");
`else
`define KCS_ASSERT_IMP(label, clk, rst, ante, cons)
`define KCS_ASSERT_NXT(label, clk, rst, ante, cons)
`define KCS_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

FILE: hdl/kcs_pkg.sv
// Shared types, codes and constants of the KCS host transaction sequencer.
// No dependencies.
package kcs_pkg;

   localparam int unsigned REQ_DEPTH_DEF = 64;

   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_VALUE = 2'd2;

   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_RESP  = 2'd2;
   localparam logic [1:0] KIND_DONE  = 2'd3;

   localparam logic PORT_DATA = 1'b0;
   localparam logic PORT_CTRL = 1'b1;

   localparam logic [2:0] FAIL_NONE  = 3'd0;
   localparam logic [2:0] FAIL_START = 3'd1;
   localparam logic [2:0] FAIL_DATA  = 3'd2;
   localparam logic [2:0] FAIL_END   = 3'd3;
   localparam logic [2:0] FAIL_READ  = 3'd4;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   localparam logic [2:0] CSR_MAX_RETRIES  = 3'd0;
   localparam logic [2:0] CSR_WRITE_START  = 3'd1;
   localparam logic [2:0] CSR_WRITE_END    = 3'd2;
   localparam logic [2:0] CSR_READ_NEXT    = 3'd3;
   localparam logic [2:0] CSR_STATUS_ABORT = 3'd4;

   localparam logic [15:0] RST_MAX_RETRIES  = 16'd1000;
   localparam logic [7:0]  RST_WRITE_START  = 8'h61;
   localparam logic [7:0]  RST_WRITE_END    = 8'h62;
   localparam logic [7:0]  RST_READ_NEXT    = 8'h68;
   localparam logic [7:0]  RST_STATUS_ABORT = 8'h60;
   localparam logic [7:0]  ABORT_DATA       = 8'h00;

   localparam int unsigned MAX_PUSH   = 3;
   localparam int unsigned RSPQ_DEPTH = 8;
   localparam int unsigned RSPQ_AW    = $clog2(RSPQ_DEPTH);
   localparam int unsigned RSPQ_CW    = $clog2(RSPQ_DEPTH + 1);

   typedef enum logic [4:0] {
      PH_IDLE, PH_W_IBF, PH_W_CHK, PH_W_CLR, PH_W_DRAIN,
      PH_R_IBF, PH_R_CHKR, PH_R_CHKI, PH_R_OBF, PH_R_DATA, PH_R_OBF_END, PH_R_DUMMY,
      PH_E_IBF0, PH_E_IBF1, PH_E_CLR, PH_E_DRAIN, PH_E_IBF2, PH_E_CHKR, PH_E_OBF,
      PH_E_DATA, PH_E_IBF3, PH_E_CHKI, PH_E_IBF4, PH_E_CLR2, PH_E_DRAIN2
   } phase_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] byte_value;
      logic [5:0] req_index;
      logic [6:0] msg_length;
   } req_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic       port_reg;
      logic [7:0] port_data;
      logic [7:0] resp_byte;
      logic [7:0] resp_index;
      logic [2:0] fail_phase;
      logic [7:0] abort_status;
      logic       comms_failure;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] max_retries;
      logic [7:0]  cmd_write_start;
      logic [7:0]  cmd_write_end;
      logic [7:0]  cmd_read_next;
      logic [7:0]  cmd_status_abort;
   } kcs_cfg_type;

   typedef struct packed {
      logic [1:0]          count;
      rsp_type [MAX_PUSH-1:0] items;
   } kcs_push_type;

endpackage

FILE: hdl/kcs_host_transaction_sequencer.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    req_type: action, byte, index, length
// rsp_      out        rsp_valid/rsp_ready    rsp_type: one port access, byte or done
// csr_      in         csr_we                 csr_index, csr_wdata (16 bit)
// One item is accepted per cycle while the result queue has room for three results.
// Results are written into the registered result queue and leave one per transfer.
// The request byte for the next data write is read from the store ahead of time.
// Reset is synchronous; the request store keeps no reset value and needs no clearing pass.
// Top level of the KCS host transaction sequencer; depends on kcs_pkg,
// kcs_req_store, kcs_seq_fsm and kcs_rsp_queue.
module kcs_host_transaction_sequencer import kcs_pkg::*; #(
   parameter int unsigned REQ_DEPTH = REQ_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   kcs_cfg_type  cfg_ff, cfg_in;
   kcs_push_type push;
   logic         req_fire;
   logic         room;
   logic [7:0]   rd_pos;
   logic [7:0]   store_byte;

   assign req_ready = room;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_RETRIES:  cfg_in.max_retries      = csr_wdata;
            CSR_WRITE_START:  cfg_in.cmd_write_start  = csr_wdata[7:0];
            CSR_WRITE_END:    cfg_in.cmd_write_end    = csr_wdata[7:0];
            CSR_READ_NEXT:    cfg_in.cmd_read_next    = csr_wdata[7:0];
            CSR_STATUS_ABORT: cfg_in.cmd_status_abort = csr_wdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_retries      <= RST_MAX_RETRIES;
         cfg_ff.cmd_write_start  <= RST_WRITE_START;
         cfg_ff.cmd_write_end    <= RST_WRITE_END;
         cfg_ff.cmd_read_next    <= RST_READ_NEXT;
         cfg_ff.cmd_status_abort <= RST_STATUS_ABORT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   kcs_req_store #(.REQ_DEPTH(REQ_DEPTH)) u_store (
      .clock    (clock),
      .wr_en    (req_fire && (req_data.action == ACT_LOAD)),
      .wr_index (req_data.req_index),
      .wr_byte  (req_data.byte_value),
      .rd_pos   (rd_pos),
      .rd_byte  (store_byte)
   );

   kcs_seq_fsm #(.REQ_DEPTH(REQ_DEPTH)) u_fsm (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .store_byte (store_byte),
      .rd_pos     (rd_pos),
      .push       (push)
   );

   kcs_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/kcs_req_store.sv
// Request byte store: one write port, one registered read port with write forwarding.
// Depends on kcs_pkg.
module kcs_req_store import kcs_pkg::*; #(
   parameter int unsigned REQ_DEPTH = REQ_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       wr_en,
   input  logic [5:0] wr_index,
   input  logic [7:0] wr_byte,
   input  logic [7:0] rd_pos,
   output logic [7:0] rd_byte
);

   localparam int unsigned AW = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;
   localparam logic [8:0]  DEPTH_W = 9'(REQ_DEPTH);

   logic [7:0]    store_mem [REQ_DEPTH];
   logic [7:0]    rd_byte_ff;
   logic [7:0]    wr_wide;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic          wr_hit;

   assign wr_wide = {2'b00, wr_index};
   assign wr_hit  = wr_en && ({1'b0, wr_wide} < DEPTH_W);
   assign wr_addr = wr_wide[AW-1:0];
   assign rd_addr = ({1'b0, rd_pos} < DEPTH_W) ? rd_pos[AW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         store_mem[wr_addr] <= wr_byte;
      end
      if (wr_hit && (wr_addr == rd_addr)) begin
         rd_byte_ff <= wr_byte;
      end else begin
         rd_byte_ff <= store_mem[rd_addr];
      end
   end

   assign rd_byte = rd_byte_ff;

endmodule

FILE: hdl/kcs_rsp_queue.sv
// Result queue: takes up to three results a cycle, hands out one per transfer.
// Depends on kcs_pkg and the assertion macro header.
`include "kcs_host_transaction_sequencer_defines.svh"
module kcs_rsp_queue import kcs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  kcs_push_type push,
   output logic         room,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   localparam logic [RSPQ_CW-1:0] ROOM_MAX = RSPQ_CW'(RSPQ_DEPTH - MAX_PUSH);

   rsp_type              queue_ff [RSPQ_DEPTH];
   logic [RSPQ_AW-1:0]   head_ff, head_in;
   logic [RSPQ_AW-1:0]   tail_ff, tail_in;
   logic [RSPQ_CW-1:0]   count_ff, count_in;
   logic                 pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = queue_ff[head_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign room      = (count_ff <= ROOM_MAX);

   assign head_in  = head_ff + RSPQ_AW'(pop);
   assign tail_in  = tail_ff + RSPQ_AW'(push.count);
   assign count_in = count_ff + RSPQ_CW'(push.count) - RSPQ_CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PUSH; i++) begin
         if (2'(i) < push.count) begin
            queue_ff[tail_ff + RSPQ_AW'(i)] <= push.items[i];
         end
      end
   end

   `KCS_ASSERT_NEVER(a_no_overflow, clock, reset, count_ff > RSPQ_CW'(RSPQ_DEPTH))
   `KCS_ASSERT_IMP(a_push_has_room, clock, reset, push.count != 2'd0, room)
   `KCS_ASSERT_NXT(a_count_tracks, clock, reset, pop && (push.count == 2'd0), count_ff == $past(count_ff) - RSPQ_CW'(1))

endmodule

FILE: hdl/kcs_seq_fsm.sv
// Transaction sequencer: phase machine, counters and result generation.
// Depends on kcs_pkg and the assertion macro header.
`include "kcs_host_transaction_sequencer_defines.svh"
module kcs_seq_fsm import kcs_pkg::*; #(
   parameter int unsigned REQ_DEPTH = REQ_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_fire,
   input  req_type      req_data,
   input  kcs_cfg_type  cfg,
   input  logic [7:0]   store_byte,
   output logic [7:0]   rd_pos,
   output kcs_push_type push
);

   localparam logic [8:0] DEPTH_W = 9'(REQ_DEPTH);

   phase_type   phase_ff, phase_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [6:0]  req_len_ff, req_len_in;
   logic [15:0] poll_count_ff, poll_count_in;
   logic [15:0] recovery_ff, recovery_in;
   logic [2:0]  fail_ff, fail_in;
   logic [7:0]  abort_ff, abort_in;

   logic [7:0]  v;
   logic [1:0]  st;
   logic        start_item, value_item;
   logic [15:0] limit;
   logic [16:0] poll_inc, rec_inc;
   logic        poll_expire, rec_expire, ibf_ok, obf_ok, bc_more;
   logic [7:0]  len_w;
   logic [6:0]  len_sat;

   function automatic rsp_type mk_port(input logic [1:0] kind, input logic preg,
                                       input logic [7:0] data);
      rsp_type r;
      r           = '0;
      r.out_kind  = kind;
      r.port_reg  = preg;
      r.port_data = data;
      return r;
   endfunction

   function automatic rsp_type mk_done(input logic [2:0] fail, input logic [7:0] abst,
                                       input logic comms);
      rsp_type r;
      r               = '0;
      r.out_kind      = KIND_DONE;
      r.fail_phase    = fail;
      r.abort_status  = abst;
      r.comms_failure = comms;
      return r;
   endfunction

   assign v          = req_data.byte_value;
   assign st         = v[7:6];
   assign start_item = req_fire && (req_data.action == ACT_START) && (phase_ff == PH_IDLE);
   assign value_item = req_fire && (req_data.action == ACT_VALUE) && (phase_ff != PH_IDLE);
   assign limit       = (cfg.max_retries == 16'd0) ? 16'd1 : cfg.max_retries;
   assign poll_inc    = {1'b0, poll_count_ff} + 17'd1;
   assign rec_inc     = {1'b0, recovery_ff} + 17'd1;
   assign poll_expire = (poll_inc >= {1'b0, limit});
   assign rec_expire  = (rec_inc >= {1'b0, limit});
   assign ibf_ok      = !v[1] || poll_expire;
   assign obf_ok      = v[0] || poll_expire;
   assign bc_more     = ({1'b0, byte_count_ff} + 9'd1) < {2'b00, req_len_ff};
   assign len_w       = (req_data.msg_length == 7'd0) ? 8'd1 : {1'b0, req_data.msg_length};
   assign len_sat     = ({1'b0, len_w} > DEPTH_W) ? DEPTH_W[6:0] : len_w[6:0];
   assign rd_pos      = byte_count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         byte_count_ff <= '0;
         req_len_ff    <= '0;
         poll_count_ff <= '0;
         recovery_ff   <= '0;
         fail_ff       <= FAIL_NONE;
         abort_ff      <= '0;
      end else begin
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
         req_len_ff    <= req_len_in;
         poll_count_ff <= poll_count_in;
         recovery_ff   <= recovery_in;
         fail_ff       <= fail_in;
         abort_ff      <= abort_in;
      end
   end

   // next state
   always_comb begin
      logic      do_wait, want_obf, do_awc, do_fail, do_retry;
      phase_type target;
      phase_in      = phase_ff;
      byte_count_in = byte_count_ff;
      req_len_in    = req_len_ff;
      poll_count_in = poll_count_ff;
      recovery_in   = recovery_ff;
      fail_in       = fail_ff;
      abort_in      = abort_ff;
      do_wait       = 1'b0;
      want_obf      = 1'b0;
      do_awc        = 1'b0;
      do_fail       = 1'b0;
      do_retry      = 1'b0;
      target        = phase_ff;
      if (start_item) begin
         req_len_in    = len_sat;
         byte_count_in = '0;
         fail_in       = FAIL_NONE;
         abort_in      = '0;
         recovery_in   = '0;
         poll_count_in = '0;
         phase_in      = PH_W_IBF;
      end else if (value_item) begin
         unique case (phase_ff)
            PH_W_IBF: begin
               do_wait = 1'b1;
               target  = (fail_ff == FAIL_NONE) ? PH_W_CLR : PH_W_CHK;
            end
            PH_W_CHK: begin
               if (st == ST_WRITE) phase_in = PH_W_CLR;
               else do_fail = 1'b1;
            end
            PH_W_CLR: begin
               if (v[0]) phase_in = PH_W_DRAIN;
               else do_awc = 1'b1;
            end
            PH_W_DRAIN: do_awc = 1'b1;
            PH_R_IBF: begin
               do_wait = 1'b1;
               target  = PH_R_CHKR;
            end
            PH_R_CHKR: begin
               if (st == ST_READ) begin
                  poll_count_in = '0;
                  phase_in      = PH_R_OBF;
               end else begin
                  phase_in = PH_R_CHKI;
               end
            end
            PH_R_CHKI: begin
               if (st == ST_IDLE) begin
                  poll_count_in = '0;
                  phase_in      = PH_R_OBF_END;
               end else begin
                  do_fail = 1'b1;
               end
            end
            PH_R_OBF: begin
               do_wait  = 1'b1;
               want_obf = 1'b1;
               target   = PH_R_DATA;
            end
            PH_R_DATA: begin
               byte_count_in = byte_count_ff + 8'd1;
               poll_count_in = '0;
               phase_in      = PH_R_IBF;
            end
            PH_R_OBF_END: begin
               do_wait  = 1'b1;
               want_obf = 1'b1;
               target   = PH_R_DUMMY;
            end
            PH_R_DUMMY: begin
               fail_in  = FAIL_NONE;
               phase_in = PH_IDLE;
            end
            PH_E_IBF0: begin
               do_wait = 1'b1;
               target  = PH_E_IBF1;
            end
            PH_E_IBF1: begin
               do_wait = 1'b1;
               target  = PH_E_CLR;
            end
            PH_E_CLR: begin
               if (v[0]) begin
                  phase_in = PH_E_DRAIN;
               end else begin
                  poll_count_in = '0;
                  phase_in      = PH_E_IBF2;
               end
            end
            PH_E_DRAIN: begin
               poll_count_in = '0;
               phase_in      = PH_E_IBF2;
            end
            PH_E_IBF2: begin
               do_wait = 1'b1;
               target  = PH_E_CHKR;
            end
            PH_E_CHKR: begin
               if (st == ST_READ) begin
                  poll_count_in = '0;
                  phase_in      = PH_E_OBF;
               end else begin
                  do_retry = 1'b1;
               end
            end
            PH_E_OBF: begin
               do_wait  = 1'b1;
               want_obf = 1'b1;
               target   = PH_E_DATA;
            end
            PH_E_DATA: begin
               abort_in      = v;
               poll_count_in = '0;
               phase_in      = PH_E_IBF3;
            end
            PH_E_IBF3: begin
               do_wait = 1'b1;
               target  = PH_E_CHKI;
            end
            PH_E_CHKI: begin
               if (st == ST_IDLE) begin
                  poll_count_in = '0;
                  phase_in      = PH_E_IBF4;
               end else begin
                  do_retry = 1'b1;
               end
            end
            PH_E_IBF4: begin
               do_wait = 1'b1;
               target  = PH_E_CLR2;
            end
            PH_E_CLR2: begin
               phase_in = v[0] ? PH_E_DRAIN2 : PH_IDLE;
            end
            PH_E_DRAIN2: phase_in = PH_IDLE;
            default: phase_in = phase_ff;
         endcase
      end

      if (do_wait) begin
         if (want_obf ? obf_ok : ibf_ok) begin
            poll_count_in = '0;
            phase_in      = target;
         end else begin
            poll_count_in = poll_inc[15:0];
         end
      end
      if (do_fail) begin
         recovery_in   = '0;
         abort_in      = '0;
         poll_count_in = '0;
         phase_in      = PH_E_IBF0;
      end
      if (do_retry) begin
         recovery_in = rec_inc[15:0];
         if (rec_expire) begin
            phase_in = PH_IDLE;
         end else begin
            poll_count_in = '0;
            phase_in      = PH_E_IBF0;
         end
      end
      if (do_awc) begin
         poll_count_in = '0;
         phase_in      = PH_W_IBF;
         if (fail_ff == FAIL_NONE) begin
            fail_in = FAIL_START;
         end else if (fail_ff == FAIL_END) begin
            byte_count_in = '0;
            fail_in       = FAIL_READ;
            phase_in      = PH_R_IBF;
         end else if (bc_more) begin
            byte_count_in = byte_count_ff + 8'd1;
            fail_in       = FAIL_DATA;
         end else begin
            fail_in = FAIL_END;
         end
      end
   end

   // results
   always_comb begin
      rsp_type rs, rd;
      rs         = mk_port(KIND_READ, PORT_CTRL, 8'd0);
      rd         = mk_port(KIND_READ, PORT_DATA, 8'd0);
      push       = '0;
      if (start_item) begin
         push.items[0] = rs;
         push.count    = 2'd1;
      end else if (value_item) begin
         unique case (phase_ff)
            PH_W_IBF, PH_W_CHK, PH_R_IBF, PH_R_CHKR, PH_R_CHKI, PH_E_IBF1, PH_E_IBF2,
            PH_E_IBF3, PH_E_IBF4: begin
               push.items[0] = rs;
               push.count    = 2'd1;
            end
            PH_W_CLR, PH_W_DRAIN: begin
               if ((phase_ff == PH_W_CLR) && v[0]) begin
                  push.items[0] = rd;
                  push.count    = 2'd1;
               end else begin
                  if (fail_ff == FAIL_NONE) begin
                     push.items[0] = mk_port(KIND_WRITE, PORT_CTRL, cfg.cmd_write_start);
                  end else if ((fail_ff == FAIL_END) || bc_more) begin
                     push.items[0] = mk_port(KIND_WRITE, PORT_DATA, store_byte);
                  end else begin
                     push.items[0] = mk_port(KIND_WRITE, PORT_CTRL, cfg.cmd_write_end);
                  end
                  push.items[1] = rs;
                  push.count    = 2'd2;
               end
            end
            PH_R_OBF, PH_R_OBF_END, PH_E_OBF: begin
               push.items[0] = obf_ok ? rd : rs;
               push.count    = 2'd1;
            end
            PH_R_DATA: begin
               push.items[0]            = '0;
               push.items[0].out_kind   = KIND_RESP;
               push.items[0].resp_byte  = v;
               push.items[0].resp_index = byte_count_ff;
               push.items[1] = mk_port(KIND_WRITE, PORT_DATA, cfg.cmd_read_next);
               push.items[2] = rs;
               push.count    = 2'd3;
            end
            PH_R_DUMMY: begin
               push.items[0] = mk_done(FAIL_NONE, 8'd0, 1'b0);
               push.count    = 2'd1;
            end
            PH_E_IBF0: begin
               if (ibf_ok) begin
                  push.items[0] = mk_port(KIND_WRITE, PORT_CTRL, cfg.cmd_status_abort);
                  push.items[1] = rs;
                  push.count    = 2'd2;
               end else begin
                  push.items[0] = rs;
                  push.count    = 2'd1;
               end
            end
            PH_E_CLR, PH_E_DRAIN: begin
               if ((phase_ff == PH_E_CLR) && v[0]) begin
                  push.items[0] = rd;
                  push.count    = 2'd1;
               end else begin
                  push.items[0] = mk_port(KIND_WRITE, PORT_DATA, ABORT_DATA);
                  push.items[1] = rs;
                  push.count    = 2'd2;
               end
            end
            PH_E_CHKR, PH_E_CHKI: begin
               if (((phase_ff == PH_E_CHKR) && (st == ST_READ)) ||
                   ((phase_ff == PH_E_CHKI) && (st == ST_IDLE)) || !rec_expire) begin
                  push.items[0] = rs;
               end else begin
                  push.items[0] = mk_done(fail_ff, 8'd0, 1'b1);
               end
               push.count = 2'd1;
            end
            PH_E_DATA: begin
               push.items[0] = mk_port(KIND_WRITE, PORT_DATA, cfg.cmd_read_next);
               push.items[1] = rs;
               push.count    = 2'd2;
            end
            PH_E_CLR2, PH_E_DRAIN2: begin
               if ((phase_ff == PH_E_CLR2) && v[0]) push.items[0] = rd;
               else push.items[0] = mk_done(fail_ff, abort_ff, 1'b0);
               push.count = 2'd1;
            end
            default: push.count = 2'd0;
         endcase
      end
      if (push.count != 2'd0) begin
         push.items[push.count - 2'd1].last = 1'b1;
      end
   end

   `KCS_ASSERT_IMP(a_push_needs_item, clock, reset, push.count != 2'd0, req_fire)
   `KCS_ASSERT_IMP(a_idle_value_silent, clock, reset, req_fire && (req_data.action == ACT_VALUE) && (phase_ff == PH_IDLE), push.count == 2'd0)
   `KCS_ASSERT_NXT(a_start_polls, clock, reset, start_item, phase_ff == PH_W_IBF)
   `KCS_ASSERT_IMP(a_last_marked, clock, reset, push.count != 2'd0, push.items[push.count - 2'd1].last)

endmodule
